// ===== sv/qdd_pkg.sv =====
package qdd_pkg;

    typedef logic [1:0]         t_pins;
    typedef logic [31:0]        t_tick;
    typedef logic signed [31:0] t_pos;
    typedef logic signed [2:0]  t_inc;
    typedef logic signed [3:0]  t_sub;

    // sub-steps per reported position step, 2 to 4
    localparam int GRANULARITY = 2;

    localparam t_sub  SUB_STEP_POS = t_sub'(GRANULARITY);
    localparam t_sub  SUB_STEP_NEG = -SUB_STEP_POS;
    localparam t_pins DETENT_HI    = 2'b11;
    localparam t_pins DETENT_LO    = 2'b00;

    function automatic logic is_detent_code(input t_pins code);
        if (GRANULARITY == 4) begin
            return code == DETENT_HI;
        end
        return (code == DETENT_HI) || (code == DETENT_LO);
    endfunction

    // transition increment, indexed by old code then new code
    function automatic t_inc inc_lookup(input t_pins last_code, input t_pins code);
        t_inc inc;
        case ({last_code, code})
            4'b0000: inc = 3'sd0;
            4'b0001: inc = 3'sd1;
            4'b0010: inc = -3'sd1;
            4'b0011: inc = 3'sd2;
            4'b0100: inc = -3'sd1;
            4'b0101: inc = 3'sd0;
            4'b0110: inc = 3'sd0;
            4'b0111: inc = 3'sd1;
            4'b1000: inc = 3'sd1;
            4'b1001: inc = 3'sd0;
            4'b1010: inc = 3'sd0;
            4'b1011: inc = -3'sd1;
            4'b1100: inc = -3'sd2;
            4'b1101: inc = -3'sd1;
            4'b1110: inc = 3'sd1;
            4'b1111: inc = 3'sd0;
            default: inc = 3'sd0;
        endcase
        return inc;
    endfunction

endpackage

// ===== sv/qdd_in_if.sv =====
interface qdd_in_if;
    logic           valid;
    logic           ready;
    qdd_pkg::t_pins pins;
    logic           enter_pressed;
    qdd_pkg::t_tick now_ms;

    modport source (output valid, output pins, output enter_pressed, output now_ms,
                    input ready);
    modport sink   (input valid, input pins, input enter_pressed, input now_ms,
                    output ready);
endinterface

// ===== sv/qdd_out_if.sv =====
interface qdd_out_if;
    logic           valid;
    logic           ready;
    qdd_pkg::t_pos  position;
    qdd_pkg::t_tick elapsed_sum;
    logic           moved;

    modport source (output valid, output position, output elapsed_sum, output moved,
                    input ready);
    modport sink   (input valid, input position, input elapsed_sum, input moved,
                    output ready);
endinterface

// ===== sv/quadrature_detent_decoder_top.sv =====
// the result word for an accepted sample word is registered and shown in the cycle after it is accepted
// throughput: one sample per cycle while the result side takes each word; the decoder state update is a registered loop
// the result register frees as it is taken, so input ready = !valid || ready at output
// reset: i_rst_n synchronous active low, clears decoder state, position, elapsed
// sum, invert mode and output valid; the first sample afterwards only captures pins
module quadrature_detent_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    qdd_in_if.sink     i_in,
    qdd_out_if.source  o_out
);

    logic            r_invert, n_invert;
    logic            r_started, n_started;
    qdd_pkg::t_pins  r_last_code, n_last_code;
    logic            r_skip, n_skip;
    qdd_pkg::t_sub   r_sub, n_sub;
    qdd_pkg::t_pos   r_position, n_position;
    qdd_pkg::t_tick  r_elapsed, n_elapsed;
    qdd_pkg::t_tick  r_change_tick, n_change_tick;
    logic            r_out_valid, n_out_valid;
    logic            r_moved, n_moved;

    logic            acc;
    qdd_pkg::t_inc   inc;
    qdd_pkg::t_sub   sum;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;

    always_comb begin
        n_invert      = i_cfg_we ? i_cfg_wdata : r_invert;
        n_started     = r_started;
        n_last_code   = r_last_code;
        n_skip        = r_skip;
        n_sub         = r_sub;
        n_position    = r_position;
        n_elapsed     = r_elapsed;
        n_change_tick = r_change_tick;
        n_moved       = r_moved;
        n_out_valid   = r_out_valid && !o_out.ready;

        inc = qdd_pkg::inc_lookup(r_last_code, i_in.pins);
        if (r_invert) begin
            inc = -inc;
        end
        sum = r_sub + qdd_pkg::t_sub'(inc);

        if (acc) begin
            n_out_valid = 1'b1;
            n_moved     = 1'b0;
            if (!r_started) begin
                // start-up capture, wait for detent when resting between
                n_started   = 1'b1;
                n_last_code = i_in.pins;
                n_skip      = !qdd_pkg::is_detent_code(i_in.pins);
            end else if (i_in.pins != r_last_code) begin
                if (r_skip) begin
                    if (qdd_pkg::is_detent_code(i_in.pins)) begin
                        n_last_code = i_in.pins;
                        n_skip      = 1'b0;
                    end
                end else begin
                    n_last_code = i_in.pins;
                    n_sub       = sum;
                    if (sum >= qdd_pkg::SUB_STEP_POS) begin
                        n_sub = sum - qdd_pkg::SUB_STEP_POS;
                        if (!i_in.enter_pressed) begin
                            n_position = r_position + 32'sd1;
                            n_moved    = 1'b1;
                        end
                    end else if (sum <= qdd_pkg::SUB_STEP_NEG) begin
                        n_sub = sum + qdd_pkg::SUB_STEP_POS;
                        if (!i_in.enter_pressed) begin
                            n_position = r_position - 32'sd1;
                            n_moved    = 1'b1;
                        end
                    end
                    if (n_moved) begin
                        n_elapsed     = r_elapsed + (i_in.now_ms - r_change_tick);
                        n_change_tick = i_in.now_ms;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert      <= 1'b0;
            r_started     <= 1'b0;
            r_last_code   <= '0;
            r_skip        <= 1'b0;
            r_sub         <= '0;
            r_position    <= '0;
            r_elapsed     <= '0;
            r_change_tick <= '0;
            r_out_valid   <= 1'b0;
            r_moved       <= 1'b0;
        end else begin
            r_invert      <= n_invert;
            r_started     <= n_started;
            r_last_code   <= n_last_code;
            r_skip        <= n_skip;
            r_sub         <= n_sub;
            r_position    <= n_position;
            r_elapsed     <= n_elapsed;
            r_change_tick <= n_change_tick;
            r_out_valid   <= n_out_valid;
            r_moved       <= n_moved;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.position    = r_position;
    assign o_out.elapsed_sum = r_elapsed;
    assign o_out.moved       = r_moved;

`ifndef SYNTHESIS
    a_first_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !r_started) |=> (o_out.valid && !o_out.moved))
        else $error("start-up capture reported a move");

    a_skip_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_started && r_skip) |=> !o_out.moved)
        else $error("move reported while waiting for detent");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub < qdd_pkg::SUB_STEP_POS) && (r_sub > qdd_pkg::SUB_STEP_NEG))
        else $error("sub-step count out of range");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> ($stable(r_position) && $stable(r_elapsed)))
        else $error("position or elapsed changed without a sample");

    a_move_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_moved) |=> (r_change_tick == $past(i_in.now_ms)))
        else $error("change tick not captured on move");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        qdd_pkg::t_pos  position;
        qdd_pkg::t_tick elapsed_sum;
        logic           moved;
    } t_result;

    // predicts the decoder and holds the result words still owed by the block
    class detent_scoreboard;
        int incr_tbl[4][4] = '{
            '{ 0,  1, -1,  2},
            '{-1,  0,  0,  1},
            '{ 1,  0,  0, -1},
            '{-2, -1,  1,  0}
        };

        bit             invert;
        bit             started;
        qdd_pkg::t_pins last_code;
        bit             skipping;
        int             sub_steps;
        logic [31:0]    position;
        qdd_pkg::t_tick elapsed;
        qdd_pkg::t_tick change_tick;
        logic [31:0]    last_reported;
        t_result        owed_results[$];
        int             fails;

        function bit is_rest_code(qdd_pkg::t_pins code);
            if (qdd_pkg::GRANULARITY == 4) begin
                return code == qdd_pkg::DETENT_HI;
            end
            return (code == qdd_pkg::DETENT_HI) || (code == qdd_pkg::DETENT_LO);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void note_sample(qdd_pkg::t_pins pins, logic enter, qdd_pkg::t_tick now);
            int      inc;
            t_result res;
            res.moved = 1'b0;
            if (!started) begin
                started   = 1'b1;
                last_code = pins;
                skipping  = !is_rest_code(pins);
            end else if (pins != last_code) begin
                if (skipping) begin
                    if (is_rest_code(pins)) begin
                        last_code = pins;
                        skipping  = 1'b0;
                    end
                end else begin
                    inc = incr_tbl[last_code][pins];
                    if (invert) begin
                        inc = -inc;
                    end
                    sub_steps += inc;
                    if (sub_steps >= qdd_pkg::GRANULARITY) begin
                        if (!enter) begin
                            position = position + 32'd1;
                        end
                        sub_steps -= qdd_pkg::GRANULARITY;
                    end else if (sub_steps <= -qdd_pkg::GRANULARITY) begin
                        if (!enter) begin
                            position = position - 32'd1;
                        end
                        sub_steps += qdd_pkg::GRANULARITY;
                    end
                    last_code = pins;
                    if (position != last_reported) begin
                        elapsed       = elapsed + (now - change_tick);
                        change_tick   = now;
                        last_reported = position;
                        res.moved     = 1'b1;
                    end
                end
            end
            res.position    = position;
            res.elapsed_sum = elapsed;
            owed_results.push_back(res);
        endfunction

        function void check_result(qdd_pkg::t_pos pos, qdd_pkg::t_tick el, logic mv);
            t_result exp_res;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result word pos=%0d elapsed=%0d moved=%0b",
                         $time, pos, el, mv);
                fails++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (pos !== exp_res.position) begin
                $display("%0t: position expected %0d actual %0d",
                         $time, exp_res.position, pos);
                fails++;
            end
            if (el !== exp_res.elapsed_sum) begin
                $display("%0t: elapsed_sum expected %0d actual %0d",
                         $time, exp_res.elapsed_sum, el);
                fails++;
            end
            if (mv !== exp_res.moved) begin
                $display("%0t: moved expected %0b actual %0b", $time, exp_res.moved, mv);
                fails++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    qdd_in_if  in_ch();
    qdd_out_if out_ch();

    detent_scoreboard sb = new();

    // idling controls, changed per phase
    bit    sender_gaps = 1'b1;
    int    sink_stall_pct = 20;
    bit    sink_long_stalls = 1'b1;

    qdd_pkg::t_pins cur_pins = '0;
    qdd_pkg::t_tick cur_now = '0;

    always #5 clk = ~clk;

    quadrature_detent_decoder_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.pins          = '0;
        in_ch.enter_pressed = 1'b0;
        in_ch.now_ms        = '0;
        out_ch.ready        = 1'b0;
    end

    // result side: short random stalls plus the odd long one
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else if (sink_long_stalls && $urandom_range(0, 149) == 0) begin
                out_ch.ready <= 1'b0;
                hold = $urandom_range(8, 40);
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.position, out_ch.elapsed_sum, out_ch.moved);
        end
    end

    initial begin
        #(5_000_000);
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_sample(input qdd_pkg::t_pins pins, input logic enter,
                               input qdd_pkg::t_tick now);
        in_ch.valid         <= 1'b1;
        in_ch.pins          <= pins;
        in_ch.enter_pressed <= enter;
        in_ch.now_ms        <= now;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        sb.note_sample(pins, enter, now);
    endtask

    // valid stays high when no gap is taken
    task automatic sender_gap();
        int n;
        int r;
        n = 0;
        if (sender_gaps) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                n = 0;
            end else if (r < 90) begin
                n = $urandom_range(1, 3);
            end else begin
                n = $urandom_range(5, 30);
            end
        end
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_invert(input bit value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.invert = value;
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic step_to(input qdd_pkg::t_pins pins, input logic enter,
                           input qdd_pkg::t_tick now);
        cur_pins = pins;
        cur_now  = now;
        send_sample(pins, enter, now);
        sender_gap();
    endtask

    function automatic qdd_pkg::t_pins gray_fwd(input qdd_pkg::t_pins c);
        case (c)
            2'b00:   return 2'b01;
            2'b01:   return 2'b11;
            2'b11:   return 2'b10;
            default: return 2'b00;
        endcase
    endfunction

    function automatic qdd_pkg::t_pins gray_back(input qdd_pkg::t_pins c);
        case (c)
            2'b00:   return 2'b10;
            2'b10:   return 2'b11;
            2'b11:   return 2'b01;
            default: return 2'b00;
        endcase
    endfunction

    task automatic random_phase(input int count, input int drain_at);
        bit             forward;
        int             r;
        qdd_pkg::t_pins nxt;
        logic           enter;
        forward = ($urandom_range(0, 1) == 1);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                forward = !forward;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                nxt = forward ? gray_fwd(cur_pins) : gray_back(cur_pins);
            end else if (r < 88) begin
                nxt = forward ? gray_back(cur_pins) : gray_fwd(cur_pins);
            end else if (r < 94) begin
                nxt = cur_pins;
            end else if (r < 97) begin
                nxt = cur_pins ^ 2'b11;  // two phases at once
            end else begin
                nxt = qdd_pkg::t_pins'($urandom_range(0, 3));
            end
            enter = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 49) == 0) begin
                cur_now = $urandom;
            end else begin
                cur_now = cur_now + $urandom_range(0, 60);
            end
            step_to(nxt, enter, cur_now);
            if (k == drain_at) begin
                drain();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_invert(1'b0);

        // start-up off detent, skip until a detent code
        step_to(2'b01, 1'b0, 32'd0);
        step_to(2'b01, 1'b0, 32'd5);
        step_to(2'b10, 1'b0, 32'd7);
        step_to(2'b00, 1'b0, 32'd9);
        // full step forward, tick at its maximum
        step_to(2'b01, 1'b0, 32'd10);
        step_to(2'b11, 1'b0, 32'hFFFF_FFFF);
        // next step wraps the tick difference
        step_to(2'b10, 1'b0, 32'd3);
        step_to(2'b00, 1'b0, 32'd20);
        // double transitions with enter held
        step_to(2'b11, 1'b1, 32'd21);
        step_to(2'b00, 1'b1, 32'd22);
        step_to(2'b00, 1'b0, 32'd25);
        // backward steps
        step_to(2'b10, 1'b0, 32'd30);
        step_to(2'b11, 1'b0, 32'd40);
        step_to(2'b01, 1'b0, 32'd41);
        step_to(2'b00, 1'b0, 32'h8000_0000);
        // zero table entries
        step_to(2'b01, 1'b0, 32'h7FFF_FFFF);
        step_to(2'b10, 1'b0, 32'h5555_5555);
        step_to(2'b01, 1'b0, 32'hAAAA_AAAA);
        step_to(2'b00, 1'b0, 32'hAAAA_AAB0);

        write_invert(1'b1);
        step_to(2'b01, 1'b0, 32'hAAAA_AAC0);
        step_to(2'b11, 1'b0, 32'hAAAA_AAD0);
        step_to(2'b01, 1'b0, 32'hAAAA_AAE0);
        step_to(2'b00, 1'b0, 32'hAAAA_AAF0);
        step_to(2'b11, 1'b0, 32'hAAAA_AB00);
        step_to(2'b00, 1'b1, 32'hAAAA_AB10);

        write_invert(1'b0);
        random_phase(235, 100);

        write_invert(1'b1);
        sender_gaps      = 1'b0;
        sink_stall_pct   = 0;
        sink_long_stalls = 1'b0;
        random_phase(235, -1);

        sender_gaps      = 1'b1;
        sink_stall_pct   = 35;
        sink_long_stalls = 1'b1;
        write_invert(1'b1);
        random_phase(235, -1);

        sink_stall_pct = 10;
        write_invert(1'b0);
        random_phase(235, 120);

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (sb.fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
